// ----- design/mstr_pkg.sv -----
// Shared types and constants for the multi-slot repeat timer.
`timescale 1ns / 1ps
`default_nettype none

package mstr_pkg;

    localparam int unsigned SLOT_COUNT_DEF = 16;
    localparam int unsigned TICK_W         = 29;

    localparam logic [7:0]  FOREVER  = 8'hFF;
    localparam logic [7:0]  NO_SLOT  = 8'hFF;

    // interval / 10 == (interval * RECIP_10) >> RECIP_SHIFT for every 32-bit interval.
    localparam logic [31:0] RECIP_10    = 32'hCCCC_CCCD;
    localparam int unsigned RECIP_SHIFT = 35;

    typedef enum logic [2:0] {
        CMD_ADD    = 3'd0,
        CMD_START  = 3'd1,
        CMD_STOP   = 3'd2,
        CMD_DELETE = 3'd3,
        CMD_TICK   = 3'd4
    } cmd_t;

    typedef enum logic [1:0] {
        MODE_UNUSED  = 2'd0,
        MODE_STOPPED = 2'd1,
        MODE_RUNNING = 2'd2
    } mode_t;

    typedef enum logic [1:0] {
        KIND_ADD_DONE = 2'd0,
        KIND_ADD_FAIL = 2'd1,
        KIND_EXPIRED  = 2'd2,
        KIND_TICK_END = 2'd3
    } kind_t;

    // Command token that walks the row of slot cells, one cell per cycle while the row advances.
    typedef struct packed {
        logic              valid;
        logic [2:0]        cmd;
        logic [7:0]        slot;
        logic [TICK_W-1:0] ticks;
        logic [7:0]        reps;
        logic              found;
    } beat_t;

    // Expiry report from one cell.
    typedef struct packed {
        logic       valid;
        logic [7:0] slot;
    } evt_t;

endpackage

`default_nettype wire

// ----- design/mstr_if.sv -----
// Valid/ready channel interfaces for commands and results.
`timescale 1ns / 1ps
`default_nettype none

interface mstr_req_if;
    logic        valid;
    logic        ready;
    logic [2:0]  cmd;
    logic [7:0]  slot_id;
    logic [31:0] interval_ms;
    logic [7:0]  repeat_count;

    modport source (output valid, cmd, slot_id, interval_ms, repeat_count, input ready);
    modport sink   (input valid, cmd, slot_id, interval_ms, repeat_count, output ready);
endinterface

interface mstr_rsp_if;
    logic       valid;
    logic       ready;
    logic [1:0] kind;
    logic [7:0] result_slot;
    logic       last;

    modport source (output valid, kind, result_slot, last, input ready);
    modport sink   (input valid, kind, result_slot, last, output ready);
endinterface

`default_nettype wire

// ----- design/multi_slot_repeat_timer_core.sv -----
// Top level of the multi-slot repeat timer: front stage, row of slot cells, result register.
`timescale 1ns / 1ps
`default_nettype none

// A command beat is accepted, its interval is scaled to 10 ms ticks in a front stage, and the
// command then walks the row of SLOT_COUNT slot cells, one cell per cycle while the row
// advances. Each cell acts on the command as it passes, so expiries come out in slot order
// during a tick. An add reports its slot or its failure, and a tick its closing result, when
// the command leaves the last cell. A held result at the result port freezes the whole row.
// The next command is accepted as soon as the previous one has left the row. Start, stop,
// delete and unknown commands walk the row too but give no result.
module multi_slot_repeat_timer_core
    import mstr_pkg::*;
#(
    parameter int unsigned SLOT_COUNT = SLOT_COUNT_DEF
)
(
    input  wire logic clk,
    input  wire logic rst_n,
    mstr_req_if.sink  req,
    mstr_rsp_if.source rsp
);

    beat_t       front_reg, front_next;
    beat_t       links [SLOT_COUNT+1];
    evt_t        evts  [SLOT_COUNT];

    logic        adv;
    logic        busy;
    logic        accept;
    logic [63:0] prod;

    logic        evt_valid;
    logic [7:0]  evt_slot;

    logic        out_valid_reg, out_valid_next;
    kind_t       out_kind_reg,  out_kind_next;
    logic [7:0]  out_slot_reg,  out_slot_next;
    logic        out_last_reg,  out_last_next;

    beat_t       tail;

    // The row moves only when the result register can take a new beat.
    assign adv    = !out_valid_reg || rsp.ready;
    assign accept = req.valid && req.ready;
    assign prod   = 64'(req.interval_ms) * 64'(RECIP_10);

    always_comb
    begin
        busy = front_reg.valid;
        for (int k = 1; k <= SLOT_COUNT; k++)
        begin
            busy = busy | links[k].valid;
        end
    end

    assign req.ready = !busy;

    always_comb
    begin
        front_next = front_reg;
        if (accept)
        begin
            front_next.valid = 1'b1;
            front_next.cmd   = req.cmd;
            front_next.slot  = req.slot_id;
            front_next.ticks = prod[RECIP_SHIFT +: TICK_W];
            front_next.reps  = req.repeat_count;
            front_next.found = 1'b0;
        end
        else if (adv)
        begin
            front_next.valid = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            front_reg <= '0;
        end
        else
        begin
            front_reg <= front_next;
        end
    end

    assign links[0] = front_reg;

    for (genvar k = 0; k < SLOT_COUNT; k++)
    begin : g_cell
        mstr_cell #(
            .INDEX (k)
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .adv      (adv),
            .beat_in  (links[k]),
            .beat_out (links[k+1]),
            .evt      (evts[k])
        );
    end

    // Only one command is in the row, so at most one cell reports per cycle.
    always_comb
    begin
        evt_valid = 1'b0;
        evt_slot  = '0;
        for (int k = 0; k < SLOT_COUNT; k++)
        begin
            evt_valid = evt_valid | evts[k].valid;
            evt_slot  = evt_slot | (evts[k].slot & {8{evts[k].valid}});
        end
    end

    assign tail = links[SLOT_COUNT];

    always_comb
    begin
        out_valid_next = 1'b0;
        out_kind_next  = KIND_TICK_END;
        out_slot_next  = NO_SLOT;
        out_last_next  = 1'b1;
        if (tail.valid && tail.cmd == CMD_ADD)
        begin
            out_valid_next = 1'b1;
            out_kind_next  = tail.found ? KIND_ADD_DONE : KIND_ADD_FAIL;
            out_slot_next  = tail.found ? tail.slot : NO_SLOT;
        end
        else if (tail.valid && tail.cmd == CMD_TICK)
        begin
            out_valid_next = 1'b1;
        end
        else if (evt_valid)
        begin
            out_valid_next = 1'b1;
            out_kind_next  = KIND_EXPIRED;
            out_slot_next  = evt_slot;
            out_last_next  = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            out_kind_reg <= out_kind_next;
            out_slot_reg <= out_slot_next;
            out_last_reg <= out_last_next;
        end
    end

    assign rsp.valid       = out_valid_reg;
    assign rsp.kind        = out_kind_reg;
    assign rsp.result_slot = out_slot_reg;
    assign rsp.last        = out_last_reg;

endmodule

`default_nettype wire

// ----- design/mstr_cell.sv -----
// One timer slot: holds the slot state and acts on the command token as it passes.
`timescale 1ns / 1ps
`default_nettype none

module mstr_cell
    import mstr_pkg::*;
#(
    parameter int unsigned INDEX = 0
)
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  adv,
    input  wire beat_t beat_in,
    output beat_t      beat_out,
    output evt_t       evt
);

    localparam logic [7:0] SELF = 8'(INDEX);

    mode_t             mode_reg,   mode_next;
    logic              alloc_reg,  alloc_next;
    logic [TICK_W-1:0] ticks_reg,  ticks_next;
    logic [TICK_W-1:0] reload_reg, reload_next;
    logic [7:0]        reps_reg,   reps_next;
    beat_t             beat_reg,   beat_next;

    logic              hit;
    logic [TICK_W-1:0] ticks_dec;

    assign hit       = (beat_in.slot == SELF);
    assign ticks_dec = ticks_reg - TICK_W'(1);

    always_comb
    begin
        mode_next   = mode_reg;
        alloc_next  = alloc_reg;
        ticks_next  = ticks_reg;
        reload_next = reload_reg;
        reps_next   = reps_reg;
        beat_next   = beat_in;
        evt.valid   = 1'b0;
        evt.slot    = SELF;
        if (beat_in.valid)
        begin
            case (beat_in.cmd)
                CMD_ADD:
                begin
                    // The first free cell along the row claims the token.
                    if (!beat_in.found && mode_reg == MODE_UNUSED)
                    begin
                        mode_next       = MODE_STOPPED;
                        alloc_next      = 1'b1;
                        ticks_next      = beat_in.ticks;
                        reload_next     = beat_in.ticks;
                        reps_next       = beat_in.reps;
                        beat_next.found = 1'b1;
                        beat_next.slot  = SELF;
                    end
                end
                CMD_START:
                begin
                    if (hit)
                    begin
                        ticks_next = reload_reg;
                        mode_next  = MODE_RUNNING;
                    end
                end
                CMD_STOP:
                begin
                    if (hit)
                    begin
                        mode_next = MODE_STOPPED;
                    end
                end
                CMD_DELETE:
                begin
                    if (hit)
                    begin
                        mode_next   = MODE_UNUSED;
                        alloc_next  = 1'b0;
                        ticks_next  = '0;
                        reload_next = '0;
                        reps_next   = '0;
                    end
                end
                CMD_TICK:
                begin
                    if (alloc_reg && mode_reg == MODE_RUNNING && ticks_reg != '0)
                    begin
                        ticks_next = ticks_dec;
                        if (ticks_dec == '0)
                        begin
                            evt.valid = 1'b1;
                            if (reps_reg == FOREVER)
                            begin
                                ticks_next = reload_reg;
                            end
                            else if (reps_reg != 8'd0)
                            begin
                                ticks_next = reload_reg;
                                reps_next  = reps_reg - 8'd1;
                                if (reps_reg == 8'd1)
                                begin
                                    mode_next = MODE_STOPPED;
                                end
                            end
                            else
                            begin
                                mode_next = MODE_STOPPED;
                            end
                        end
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= MODE_UNUSED;
            alloc_reg  <= 1'b0;
            ticks_reg  <= '0;
            reload_reg <= '0;
            reps_reg   <= '0;
            beat_reg   <= '0;
        end
        else if (adv)
        begin
            mode_reg   <= mode_next;
            alloc_reg  <= alloc_next;
            ticks_reg  <= ticks_next;
            reload_reg <= reload_next;
            reps_reg   <= reps_next;
            beat_reg   <= beat_next;
        end
    end

    assign beat_out = beat_reg;

endmodule

`default_nettype wire
